// ----- design/cst_pkg.sv -----
// Shared types, constants and sine table of the circle sector tessellator.
package cst_pkg;

    localparam int DEG_FULL = 360;
    localparam int DEG_QUARTER = 90;
    // Largest unreduced end angle: widest end_deg plus widest rotation_deg
    localparam int STOP_MAX = (2 ** 10 - 1) + (2 ** 9 - 1);
    localparam int TRIG_ONE = 16384;
    localparam int XY_FRAC = 28;

    // round(2^14 * sin(d deg)) for d = 0..90
    localparam logic [14:0] QSIN [91] = '{
        15'd0,     15'd286,   15'd572,   15'd857,   15'd1143,  15'd1428,  15'd1713,
        15'd1997,  15'd2280,  15'd2563,  15'd2845,  15'd3126,  15'd3406,  15'd3686,
        15'd3964,  15'd4240,  15'd4516,  15'd4790,  15'd5063,  15'd5334,  15'd5604,
        15'd5872,  15'd6138,  15'd6402,  15'd6664,  15'd6924,  15'd7182,  15'd7438,
        15'd7692,  15'd7943,  15'd8192,  15'd8438,  15'd8682,  15'd8923,  15'd9162,
        15'd9397,  15'd9630,  15'd9860,  15'd10087, 15'd10311, 15'd10531, 15'd10749,
        15'd10963, 15'd11174, 15'd11381, 15'd11585, 15'd11786, 15'd11982, 15'd12176,
        15'd12365, 15'd12551, 15'd12733, 15'd12911, 15'd13085, 15'd13255, 15'd13421,
        15'd13583, 15'd13741, 15'd13894, 15'd14044, 15'd14189, 15'd14330, 15'd14466,
        15'd14598, 15'd14726, 15'd14849, 15'd14968, 15'd15082, 15'd15191, 15'd15296,
        15'd15396, 15'd15491, 15'd15582, 15'd15668, 15'd15749, 15'd15826, 15'd15897,
        15'd15964, 15'd16026, 15'd16083, 15'd16135, 15'd16182, 15'd16225, 15'd16262,
        15'd16294, 15'd16322, 15'd16344, 15'd16362, 15'd16374, 15'd16382, 15'd16384
    };

    typedef enum logic [1:0] {
        CFG_U_SCALE = 2'd0,
        CFG_U_BASE  = 2'd1,
        CFG_V_SCALE = 2'd2,
        CFG_V_BASE  = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_STEP,
        SEQ_CLOSE
    } seq_state_t;

    typedef struct packed {
        logic signed [15:0] ctr_x;
        logic signed [15:0] ctr_y;
        logic [14:0]        radius_x;
        logic [14:0]        radius_y;
        logic [8:0]         start_deg;
        logic [9:0]         end_deg;
        logic [8:0]         rotation_deg;
        logic [31:0]        color;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] vert_x;
        logic signed [15:0] vert_y;
        logic [15:0]        tex_u;
        logic [15:0]        tex_v;
        logic [31:0]        vert_color;
        logic               last;
    } out_item_t;

    // One classified request as handed from front to back
    typedef struct packed {
        logic signed [15:0] cx;
        logic signed [15:0] cy;
        logic [14:0]        rx;
        logic [14:0]        ry;
        logic [9:0]         a0;
        logic [8:0]         a0m;
        logic [10:0]        stop;
        logic [8:0]         stopm;
        logic signed [15:0] cr;
        logic signed [15:0] sr;
        logic [31:0]        color;
    } cmd_t;

    typedef struct packed {
        logic [16:0] u_scale;
        logic [15:0] u_base;
        logic [16:0] v_scale;
        logic [15:0] v_base;
    } tex_cfg_t;

    // Reduce an angle below STOP_MAX modulo 360
    function automatic logic [8:0] mod360(input logic [10:0] v);
        logic [10:0] r;
        r = v;
        for (int i = 0; i < 4; i++)
        begin
            if (r >= 11'(DEG_FULL))
            begin
                r = r - 11'(DEG_FULL);
            end
        end
        return r[8:0];
    endfunction

    // Q1.14 sine of a reduced angle (0..359)
    function automatic logic signed [15:0] rom_sin(input logic [8:0] d);
        logic [6:0]  idx;
        logic        neg;
        logic [15:0] mag;
        if (d <= 9'd90)
        begin
            idx = d[6:0];
            neg = 1'b0;
        end
        else if (d <= 9'd180)
        begin
            idx = 7'(9'd180 - d);
            neg = 1'b0;
        end
        else if (d <= 9'd270)
        begin
            idx = 7'(d - 9'd180);
            neg = 1'b1;
        end
        else
        begin
            idx = 7'(9'd360 - d);
            neg = 1'b1;
        end
        mag = {1'b0, QSIN[idx]};
        return neg ? $signed(-mag) : $signed(mag);
    endfunction

    function automatic logic signed [15:0] rom_cos(input logic [8:0] d);
        logic [9:0] e;
        e = 10'(d) + 10'(DEG_QUARTER);
        if (e >= 10'(DEG_FULL))
        begin
            e = e - 10'(DEG_FULL);
        end
        return rom_sin(e[8:0]);
    endfunction

endpackage

// ----- design/cst_fifo.sv -----
// Small first-word-fall-through queue of flip-flop entries.
module cst_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty,
    output logic             full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_wr, do_rd;

    assign empty = (cnt_reg == '0);
    assign full  = (cnt_reg == CNT_W'(DEPTH));
    assign do_wr = wr_en && !full;
    assign do_rd = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_wr) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        cnt_next = cnt_reg + CNT_W'(do_wr) - CNT_W'(do_rd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ----- design/cst_front.sv -----
// Front end: takes request items and classifies them into sequencer commands.
module cst_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  cst_pkg::in_item_t req,
    output logic              full,
    output logic              cq_wr,
    output cst_pkg::cmd_t     cq_data,
    input  logic              cq_full
);

    logic              fv_reg, fv_next;
    cst_pkg::in_item_t item_reg;
    logic              accept;
    logic [8:0]        rot_m;
    logic [9:0]        a0;
    logic [10:0]       stop;

    assign full   = fv_reg && cq_full;
    assign accept = push && !full;
    assign cq_wr  = fv_reg && !cq_full;
    assign fv_next = accept || (fv_reg && cq_full);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fv_reg <= 1'b0;
        end
        else
        begin
            fv_reg <= fv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= req;
        end
    end

    // Angles stay unreduced for the end test; reduced copies feed the sine table
    always_comb
    begin
        rot_m = cst_pkg::mod360(11'(item_reg.rotation_deg));
        a0    = 10'(item_reg.start_deg) + 10'(item_reg.rotation_deg);
        stop  = 11'(item_reg.end_deg) + 11'(item_reg.rotation_deg);
        cq_data.cx    = item_reg.ctr_x;
        cq_data.cy    = item_reg.ctr_y;
        cq_data.rx    = item_reg.radius_x;
        cq_data.ry    = item_reg.radius_y;
        cq_data.a0    = a0;
        cq_data.a0m   = cst_pkg::mod360(11'(a0));
        cq_data.stop  = stop;
        cq_data.stopm = cst_pkg::mod360(stop);
        cq_data.cr    = cst_pkg::rom_cos(rot_m);
        cq_data.sr    = cst_pkg::rom_sin(rot_m);
        cq_data.color = item_reg.color;
    end

endmodule

// ----- design/cst_back.sv -----
// Back end: angle sequencer and vertex arithmetic pipeline.
module cst_back #(
    parameter int MAX_STEPS  = 60,
    parameter int ANGLE_STEP = 6,
    parameter int OQ_DEPTH   = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  cst_pkg::cmd_t      cmd,
    input  logic               cmd_empty,
    output logic               cmd_rd,
    input  cst_pkg::tex_cfg_t  tex_cfg,
    input  logic               vtx_taken,
    output logic               wr_en,
    output cst_pkg::out_item_t wr_item
);

    localparam int ANG_W = $clog2(cst_pkg::STOP_MAX + MAX_STEPS * ANGLE_STEP + 1);
    localparam int CNT_W = $clog2(MAX_STEPS + 1);
    localparam int RES_W = $clog2(OQ_DEPTH + 1);
    localparam int SUM_W = 48;

    typedef struct packed {
        logic               last;
        logic signed [15:0] c;
        logic signed [15:0] s;
        logic signed [15:0] cx;
        logic signed [15:0] cy;
        logic [14:0]        rx;
        logic [14:0]        ry;
        logic signed [15:0] cr;
        logic signed [15:0] sr;
        logic [31:0]        color;
    } st1_t;

    typedef struct packed {
        logic               last;
        logic signed [31:0] dx;
        logic signed [31:0] dy;
        logic [32:0]        tup;
        logic [32:0]        tvp;
        logic signed [15:0] cx;
        logic signed [15:0] cy;
        logic signed [15:0] cr;
        logic signed [15:0] sr;
        logic [31:0]        color;
    } st2_t;

    typedef struct packed {
        logic               last;
        logic signed [47:0] px1;
        logic signed [47:0] px2;
        logic signed [47:0] py1;
        logic signed [47:0] py2;
        logic [15:0]        tu;
        logic [15:0]        tv;
        logic signed [15:0] cx;
        logic signed [15:0] cy;
        logic [31:0]        color;
    } st3_t;

    cst_pkg::seq_state_t state_reg, state_next;
    cst_pkg::cmd_t       cur_reg;
    logic [ANG_W-1:0]    a_reg, a_n;
    logic [8:0]          am_reg, am_n;
    logic [9:0]          am_sum;
    logic [CNT_W-1:0]    cnt_reg;
    logic [RES_W-1:0]    res_reg, res_next;
    logic                credit_ok, issue, step_adv;
    logic                past_end, at_end, limit_hit;
    logic [8:0]          s0_deg;
    logic                s0_last;

    logic                v1_reg, v2_reg, v3_reg;
    st1_t                s1_reg, s1_next;
    st2_t                s2_reg, s2_next;
    st3_t                s3_reg, s3_next;

    assign credit_ok = (res_reg < RES_W'(OQ_DEPTH));
    assign a_n       = a_reg + ANG_W'(ANGLE_STEP);
    assign am_sum    = 10'(am_reg) + 10'(ANGLE_STEP);
    assign am_n      = (am_sum >= 10'(cst_pkg::DEG_FULL)) ? 9'(am_sum - 10'(cst_pkg::DEG_FULL))
                                                        : am_sum[8:0];
    assign past_end  = (a_n > ANG_W'(cur_reg.stop));
    assign at_end    = (a_n == ANG_W'(cur_reg.stop));
    assign limit_hit = (cnt_reg == CNT_W'(MAX_STEPS - 1));
    assign step_adv  = issue && (state_reg == cst_pkg::SEQ_STEP);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            cst_pkg::SEQ_IDLE: begin
                if (!cmd_empty) begin
                    state_next = cst_pkg::SEQ_STEP;
                end
            end
            cst_pkg::SEQ_STEP: begin
                if (credit_ok) begin
                    if (past_end) begin
                        state_next = cst_pkg::SEQ_CLOSE;
                    end else if (at_end || limit_hit) begin
                        state_next = cst_pkg::SEQ_IDLE;
                    end
                end
            end
            cst_pkg::SEQ_CLOSE: begin
                if (credit_ok) begin
                    state_next = cst_pkg::SEQ_IDLE;
                end
            end
            default: state_next = cst_pkg::SEQ_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        cmd_rd  = 1'b0;
        issue   = 1'b0;
        s0_deg  = am_reg;
        s0_last = 1'b0;
        case (state_reg)
            cst_pkg::SEQ_IDLE: begin
                cmd_rd = !cmd_empty;
            end
            cst_pkg::SEQ_STEP: begin
                issue   = credit_ok;
                s0_last = !past_end && (at_end || limit_hit);
            end
            cst_pkg::SEQ_CLOSE: begin
                issue   = credit_ok;
                s0_deg  = cur_reg.stopm;
                s0_last = 1'b1;
            end
            default: begin
                issue = 1'b0;
            end
        endcase
    end

    // Count slots taken in pipeline and result queue together
    assign res_next = res_reg + RES_W'(issue) - RES_W'(vtx_taken);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= cst_pkg::SEQ_IDLE;
            cnt_reg   <= '0;
            res_reg   <= '0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            res_reg   <= res_next;
            v1_reg    <= issue;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            if (cmd_rd) begin
                cnt_reg <= '0;
            end else if (step_adv) begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_rd) begin
            cur_reg <= cmd;
            a_reg   <= ANG_W'(cmd.a0);
            am_reg  <= cmd.a0m;
        end else if (step_adv) begin
            a_reg  <= a_n;
            am_reg <= am_n;
        end
    end

    // Stage 1: table lookup
    always_comb
    begin
        s1_next.last  = s0_last;
        s1_next.c     = cst_pkg::rom_cos(s0_deg);
        s1_next.s     = cst_pkg::rom_sin(s0_deg);
        s1_next.cx    = cur_reg.cx;
        s1_next.cy    = cur_reg.cy;
        s1_next.rx    = cur_reg.rx;
        s1_next.ry    = cur_reg.ry;
        s1_next.cr    = cur_reg.cr;
        s1_next.sr    = cur_reg.sr;
        s1_next.color = cur_reg.color;
    end

    // Stage 2: scale by radii and texture scales
    always_comb
    begin
        logic [15:0] tu_t, tv_t;
        tu_t = 16'(s1_reg.c + 16'sd16384);
        tv_t = 16'(s1_reg.s + 16'sd16384);
        s2_next.last  = s1_reg.last;
        s2_next.dx    = s1_reg.c * $signed({1'b0, s1_reg.rx});
        s2_next.dy    = s1_reg.s * $signed({1'b0, s1_reg.ry});
        s2_next.tup   = 33'(tu_t) * 33'(tex_cfg.u_scale);
        s2_next.tvp   = 33'(tv_t) * 33'(tex_cfg.v_scale);
        s2_next.cx    = s1_reg.cx;
        s2_next.cy    = s1_reg.cy;
        s2_next.cr    = s1_reg.cr;
        s2_next.sr    = s1_reg.sr;
        s2_next.color = s1_reg.color;
    end

    // Stage 3: rotate; finish texture coordinates
    always_comb
    begin
        logic [19:0] tu_w, tv_w;
        tu_w = 20'((34'(s2_reg.tup) + 34'(cst_pkg::TRIG_ONE)) >> 15) + 20'(tex_cfg.u_base);
        tv_w = 20'((34'(s2_reg.tvp) + 34'(cst_pkg::TRIG_ONE)) >> 15) + 20'(tex_cfg.v_base);
        s3_next.last  = s2_reg.last;
        s3_next.px1   = s2_reg.dx * s2_reg.cr;
        s3_next.px2   = s2_reg.dy * s2_reg.sr;
        s3_next.py1   = s2_reg.dy * s2_reg.cr;
        s3_next.py2   = s2_reg.dx * s2_reg.sr;
        s3_next.tu    = (tu_w > 20'hFFFF) ? 16'hFFFF : tu_w[15:0];
        s3_next.tv    = (tv_w > 20'hFFFF) ? 16'hFFFF : tv_w[15:0];
        s3_next.cx    = s2_reg.cx;
        s3_next.cy    = s2_reg.cy;
        s3_next.color = s2_reg.color;
    end

    always_ff @(posedge clk)
    begin
        s1_reg <= s1_next;
        s2_reg <= s2_next;
        s3_reg <= s3_next;
    end

    // Stage 4: add the centre, round half up by 2^-28, saturate
    always_comb
    begin
        logic signed [SUM_W-1:0] xs, ys;
        logic signed [19:0]      xr, yr;
        xs = $signed({{(SUM_W - 16 - cst_pkg::XY_FRAC){s3_reg.cx[15]}}, s3_reg.cx,
                      {cst_pkg::XY_FRAC{1'b0}}}) + s3_reg.px1 + s3_reg.px2;
        ys = $signed({{(SUM_W - 16 - cst_pkg::XY_FRAC){s3_reg.cy[15]}}, s3_reg.cy,
                      {cst_pkg::XY_FRAC{1'b0}}}) + s3_reg.py1 - s3_reg.py2;
        xs = xs + SUM_W'(2 ** (cst_pkg::XY_FRAC - 1));
        ys = ys + SUM_W'(2 ** (cst_pkg::XY_FRAC - 1));
        xr = xs[SUM_W-1-:20];
        yr = ys[SUM_W-1-:20];
        if (xr > 20'sd32767) begin
            wr_item.vert_x = 16'sh7FFF;
        end else if (xr < -20'sd32768) begin
            wr_item.vert_x = 16'sh8000;
        end else begin
            wr_item.vert_x = xr[15:0];
        end
        if (yr > 20'sd32767) begin
            wr_item.vert_y = 16'sh7FFF;
        end else if (yr < -20'sd32768) begin
            wr_item.vert_y = 16'sh8000;
        end else begin
            wr_item.vert_y = yr[15:0];
        end
        wr_item.tex_u      = s3_reg.tu;
        wr_item.tex_v      = s3_reg.tv;
        wr_item.vert_color = s3_reg.color;
        wr_item.last       = s3_reg.last;
    end

    assign wr_en = v3_reg;

`ifndef ASSERT_OFF
    a_res_bound: assert property (@(posedge clk) disable iff (!rst_n)
        res_reg <= RES_W'(OQ_DEPTH))
        else $error("slot count exceeds result queue depth");
    a_wr_has_slot: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (res_reg != '0))
        else $error("vertex written without a reserved slot");
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (issue && s0_last) |=> (state_reg == cst_pkg::SEQ_IDLE))
        else $error("sequencer kept running after the final vertex");
    a_angle_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == cst_pkg::SEQ_STEP) |-> (am_reg < 9'(cst_pkg::DEG_FULL)))
        else $error("reduced angle out of range");
`endif

endmodule

// ----- design/circle_sector_tessellator.sv -----
// Top level of the circle sector tessellator: front, command queue, back, result queue.
//
//  Channel   Handshake          Payload / fields
//  req       push, full         in_item_t
//  vtx       empty, pop         out_item_t
//  cfg       cfg_we             cfg_addr, cfg_data
//
// A request yields 1 to MAX_STEPS+1 rim vertices; the back end issues one vertex per
// cycle while a result slot is free, after an idle state that loads the command.
// The first vertex passes front, command queue, sequencer, pipeline and result queue.
// Reset empties both queues and loads the texture registers with their defaults.
// The sequencer issues only while the result queue has a slot not yet claimed by the
// pipeline; a full command queue stalls the front, which then raises full.
module circle_sector_tessellator #(
    parameter int MAX_STEPS  = 60,
    parameter int ANGLE_STEP = 6
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  cst_pkg::in_item_t  req,
    output logic               empty,
    input  logic               pop,
    output cst_pkg::out_item_t vtx,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_addr,
    input  logic [16:0]        cfg_data
);

    localparam int CQ_DEPTH = 2;
    localparam int OQ_DEPTH = 8;

    cst_pkg::tex_cfg_t  cfg_reg;
    cst_pkg::cmd_t      cq_wdata, cq_rdata;
    logic               cq_wr, cq_rd, cq_full, cq_empty;
    logic               oq_wr, oq_full;
    cst_pkg::out_item_t oq_wdata;
    logic               vtx_taken;

    assign vtx_taken = pop && !empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.u_scale <= 17'd65536;
            cfg_reg.u_base  <= 16'd0;
            cfg_reg.v_scale <= 17'd65536;
            cfg_reg.v_base  <= 16'd0;
        end
        else if (cfg_we)
        begin
            case (cst_pkg::cfg_idx_t'(cfg_addr))
                cst_pkg::CFG_U_SCALE: cfg_reg.u_scale <= cfg_data;
                cst_pkg::CFG_U_BASE:  cfg_reg.u_base  <= cfg_data[15:0];
                cst_pkg::CFG_V_SCALE: cfg_reg.v_scale <= cfg_data;
                cst_pkg::CFG_V_BASE:  cfg_reg.v_base  <= cfg_data[15:0];
                default:              cfg_reg <= cfg_reg;
            endcase
        end
    end

    cst_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .req     (req),
        .full    (full),
        .cq_wr   (cq_wr),
        .cq_data (cq_wdata),
        .cq_full (cq_full)
    );

    cst_fifo #(
        .WIDTH ($bits(cst_pkg::cmd_t)),
        .DEPTH (CQ_DEPTH)
    ) u_cmd_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cq_wr),
        .wr_data (cq_wdata),
        .rd_en   (cq_rd),
        .rd_data (cq_rdata),
        .empty   (cq_empty),
        .full    (cq_full)
    );

    cst_back #(
        .MAX_STEPS  (MAX_STEPS),
        .ANGLE_STEP (ANGLE_STEP),
        .OQ_DEPTH   (OQ_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cq_rdata),
        .cmd_empty (cq_empty),
        .cmd_rd    (cq_rd),
        .tex_cfg   (cfg_reg),
        .vtx_taken (vtx_taken),
        .wr_en     (oq_wr),
        .wr_item   (oq_wdata)
    );

    cst_fifo #(
        .WIDTH ($bits(cst_pkg::out_item_t)),
        .DEPTH (OQ_DEPTH)
    ) u_out_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (oq_wr),
        .wr_data (oq_wdata),
        .rd_en   (pop),
        .rd_data (vtx),
        .empty   (empty),
        .full    (oq_full)
    );

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        oq_wr |-> !oq_full)
        else $error("vertex written into a full result queue");
`endif

endmodule

// ----- bench/circle_sector_tessellator_check.sv -----
// Scoreboard for the circle sector tessellator: predicts rim vertices and checks each one.
`timescale 1ns / 100ps

module circle_sector_tessellator_check
    import cst_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  logic       full,
    input  in_item_t   req,
    input  logic       empty,
    input  logic       pop,
    input  out_item_t  vtx,
    input  logic       cfg_we,
    input  logic [1:0] cfg_addr,
    input  logic [16:0] cfg_data,
    output int         errors,
    output int         pending,
    output int         sectors,
    output int         vertices
);

    localparam int MAX_STEPS   = 60;
    localparam int ANGLE_STEP  = 6;
    localparam int MAX_REPORTS = 30;

    logic [16:0] u_scale;
    logic [15:0] u_base;
    logic [16:0] v_scale;
    logic [15:0] v_base;

    out_item_t rim_due[$];
    int        fail_count;
    int        sector_count;
    int        vertex_count;

    function automatic int sine_q14(int deg);
        int d;
        d = deg % DEG_FULL;
        if (d <= DEG_QUARTER)
        begin
            return int'(QSIN[d]);
        end
        if (d <= 2 * DEG_QUARTER)
        begin
            return int'(QSIN[2 * DEG_QUARTER - d]);
        end
        if (d <= 3 * DEG_QUARTER)
        begin
            return -int'(QSIN[d - 2 * DEG_QUARTER]);
        end
        return -int'(QSIN[DEG_FULL - d]);
    endfunction

    function automatic int cosine_q14(int deg);
        return sine_q14(deg % DEG_FULL + DEG_QUARTER);
    endfunction

    function automatic logic [15:0] clamp_s16(longint v);
        if (v > 32767)
        begin
            return 16'h7fff;
        end
        if (v < -32768)
        begin
            return 16'h8000;
        end
        return 16'(v);
    endfunction

    // (trig + 1) / 2 in Q0.15, times scale, rounded half up, plus base
    function automatic logic [15:0] tex_coord(int trig, longint scale, longint base);
        longint r;
        r = ((longint'(trig + TRIG_ONE) * scale) + 16384) >>> 15;
        r = r + base;
        return (r > 65535) ? 16'hffff : 16'(r);
    endfunction

    function automatic out_item_t rim_vertex(int ang, longint cx, longint cy, longint rx,
                                             longint ry, int cr, int sr, logic [31:0] color);
        int        c;
        int        s;
        longint    dx;
        longint    dy;
        longint    xs;
        longint    ys;
        longint    half;
        out_item_t v;
        c    = cosine_q14(ang);
        s    = sine_q14(ang);
        dx   = c * rx;
        dy   = s * ry;
        xs   = cx * (longint'(1) <<< XY_FRAC) + dx * cr + dy * sr;
        ys   = cy * (longint'(1) <<< XY_FRAC) + dy * cr - dx * sr;
        half = longint'(1) <<< (XY_FRAC - 1);
        v.vert_x     = clamp_s16((xs + half) >>> XY_FRAC);
        v.vert_y     = clamp_s16((ys + half) >>> XY_FRAC);
        // texture follows the stepped angle, before the cr/sr rotation
        v.tex_u      = tex_coord(c, longint'(u_scale), longint'(u_base));
        v.tex_v      = tex_coord(s, longint'(v_scale), longint'(v_base));
        v.vert_color = color;
        v.last       = 1'b0;
        return v;
    endfunction

    function automatic void tessellate_sector(in_item_t it);
        longint cx;
        longint cy;
        longint rx;
        longint ry;
        int     cr;
        int     sr;
        int     ang;
        int     stop;
        cx   = longint'($signed(it.ctr_x));
        cy   = longint'($signed(it.ctr_y));
        rx   = longint'(it.radius_x);
        ry   = longint'(it.radius_y);
        cr   = cosine_q14(int'(it.rotation_deg));
        sr   = sine_q14(int'(it.rotation_deg));
        // compare against the unreduced sums, reduce only for lookup
        ang  = int'(it.start_deg) + int'(it.rotation_deg);
        stop = int'(it.end_deg) + int'(it.rotation_deg);
        for (int i = 0; i < MAX_STEPS; i++)
        begin
            rim_due.push_back(rim_vertex(ang, cx, cy, rx, ry, cr, sr, it.color));
            ang = ang + ANGLE_STEP;
            if (ang > stop)
            begin
                rim_due.push_back(rim_vertex(stop, cx, cy, rx, ry, cr, sr, it.color));
                break;
            end
            if (ang == stop)
            begin
                break;
            end
        end
        rim_due[rim_due.size() - 1].last = 1'b1;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
            begin
                $display("%0t: vertex %0d %s expected %h, got %h",
                         $time, vertex_count, name, want, got);
            end
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t due;
        if (!rst_n)
        begin
            u_scale      = 17'h10000;
            u_base       = 16'h0000;
            v_scale      = 17'h10000;
            v_base       = 16'h0000;
            rim_due.delete();
            fail_count   = 0;
            sector_count = 0;
            vertex_count = 0;
            errors   <= 0;
            pending  <= 0;
            sectors  <= 0;
            vertices <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_idx_t'(cfg_addr))
                    CFG_U_SCALE: u_scale = cfg_data;
                    CFG_U_BASE:  u_base  = cfg_data[15:0];
                    CFG_V_SCALE: v_scale = cfg_data;
                    CFG_V_BASE:  v_base  = cfg_data[15:0];
                    default:     ;
                endcase
            end
            // match results before adding this edge's sector, so a stray item cannot pair up
            if (pop && !empty)
            begin
                if (rim_due.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                    begin
                        $display("%0t: vertex %0d expected none, got %h",
                                 $time, vertex_count, vtx);
                    end
                end
                else
                begin
                    due = rim_due.pop_front();
                    check_field("vert_x", due.vert_x, vtx.vert_x);
                    check_field("vert_y", due.vert_y, vtx.vert_y);
                    check_field("tex_u", due.tex_u, vtx.tex_u);
                    check_field("tex_v", due.tex_v, vtx.tex_v);
                    check_field("vert_color", due.vert_color, vtx.vert_color);
                    check_field("last", due.last, vtx.last);
                end
                vertex_count++;
            end
            if (push && !full)
            begin
                tessellate_sector(req);
                sector_count++;
            end
            errors   <= fail_count;
            pending  <= rim_due.size();
            sectors  <= sector_count;
            vertices <= vertex_count;
        end
    end

endmodule

// ----- bench/circle_sector_tessellator_tb.sv -----
// Testbench top for the circle sector tessellator: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module circle_sector_tessellator_tb;
    import cst_pkg::*;

    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int HOLD_CYCLES = 600;
    localparam int TAIL_CYCLES = 20;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        push     = 1'b0;
    logic        pop      = 1'b0;
    logic        cfg_we   = 1'b0;
    logic [1:0]  cfg_addr = '0;
    logic [16:0] cfg_data = '0;
    in_item_t    req      = '0;
    logic        full;
    logic        empty;
    out_item_t   vtx;

    int errors;
    int pending;
    int sectors;
    int vertices;

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_len      = 0;
    int hold_req      = 0;
    int hold_seen     = 0;
    int hold_left     = 0;
    int cycles        = 0;
    int settings      = 1;

    circle_sector_tessellator u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .req      (req),
        .empty    (empty),
        .pop      (pop),
        .vtx      (vtx),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data)
    );

    circle_sector_tessellator_check u_check (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .req      (req),
        .empty    (empty),
        .pop      (pop),
        .vtx      (vtx),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .errors   (errors),
        .pending  (pending),
        .sectors  (sectors),
        .vertices (vertices)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d vertices still due", cycles, pending);
            $display("TEST FAILED");
            $finish;
        end
    end

    // Result side: random stalls, plus a long hold-off on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pop       <= 1'b0;
            hold_seen <= 0;
            hold_left <= 0;
        end
        else if (hold_req != hold_seen)
        begin
            hold_seen <= hold_req;
            hold_left <= hold_len;
            pop       <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            pop       <= 1'b0;
        end
        else
        begin
            pop <= ($urandom_range(99) >= stall_pct);
        end
    end

    function automatic in_item_t sector(int cx, int cy, int rx, int ry, int s, int e, int r,
                                        logic [31:0] col);
        in_item_t it;
        it.ctr_x        = 16'(cx);
        it.ctr_y        = 16'(cy);
        it.radius_x     = 15'(rx);
        it.radius_y     = 15'(ry);
        it.start_deg    = 9'(s);
        it.end_deg      = 10'(e);
        it.rotation_deg = 9'(r);
        it.color        = col;
        return it;
    endfunction

    function automatic in_item_t random_sector();
        in_item_t it;
        int       kind;
        int       s;
        kind        = $urandom_range(99);
        it.ctr_x    = 16'($urandom);
        it.ctr_y    = 16'($urandom);
        it.radius_x = ($urandom_range(9) < 3) ? 15'($urandom_range(4095)) : 15'($urandom);
        it.radius_y = ($urandom_range(9) < 3) ? 15'($urandom_range(4095)) : 15'($urandom);
        it.color    = $urandom;
        s           = $urandom_range(DEG_FULL - 1);
        it.start_deg = 9'(s);
        it.rotation_deg = ($urandom_range(9) < 3) ? 9'd0 : 9'($urandom_range(DEG_FULL - 1));
        if (kind < 55)
        begin
            it.end_deg = 10'(s + $urandom_range(DEG_FULL));
        end
        else if (kind < 80)
        begin
            it.end_deg = 10'(s + $urandom_range(30));
        end
        else if (kind < 90)
        begin
            // start at or beyond end
            it.end_deg = 10'($urandom_range(s));
        end
        else
        begin
            // angles anywhere the fields reach
            it.start_deg    = 9'($urandom);
            it.end_deg      = 10'($urandom);
            it.rotation_deg = 9'($urandom);
        end
        return it;
    endfunction

    task automatic offer(input in_item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        req  <= it;
        push <= 1'b1;
        @(posedge clk);
        while (full)
        begin
            @(posedge clk);
        end
    endtask

    task automatic reg_write(input cfg_idx_t idx, input logic [16:0] val);
        cfg_we   <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val;
        @(posedge clk);
    endtask

    task automatic program_regs(input logic [16:0] us, input logic [16:0] ub,
                                input logic [16:0] vs, input logic [16:0] vb);
        reg_write(CFG_U_SCALE, us);
        reg_write(CFG_U_BASE, ub);
        reg_write(CFG_V_SCALE, vs);
        reg_write(CFG_V_BASE, vb);
        cfg_we <= 1'b0;
        settings++;
    endtask

    task automatic drain();
        push <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic run_random(input int count);
        repeat (count)
        begin
            offer(random_sector());
        end
    endtask

    task automatic directed_sectors();
        offer(sector(0, 0, 1600, 1600, 0, 90, 0, 32'h11223344));
        // lands exactly on the end
        offer(sector(0, 0, 1600, 800, 0, 60, 0, 32'h55667788));
        // closing vertex after overshoot
        offer(sector(160, -160, 800, 800, 10, 23, 0, 32'h99aabbcc));
        // step limit with widest radii
        offer(sector(0, 0, 32767, 32767, 0, 719, 0, 32'hddeeff00));
        offer(sector(0, 0, 4000, 4000, 300, 10, 0, 32'h01020304));
        offer(sector(100, 100, 500, 500, 45, 45, 0, 32'h0a0b0c0d));
        offer(sector(-32768, -32768, 32767, 32767, 180, 270, 0, 32'h80000001));
        offer(sector(32767, 32767, 32767, 32767, 0, 90, 0, 32'h7ffffffe));
        offer(sector(0, 0, 0, 0, 0, 30, 0, 32'hffffffff));
        offer(sector(800, -800, 1200, 600, 0, 120, 90, 32'h12345678));
        offer(sector(-4000, 2000, 3000, 3000, 30, 200, 180, 32'h87654321));
        offer(sector(0, 0, 2000, 1000, 0, 359, 359, 32'hcafe0001));
        offer(sector(50, 50, 2500, 2500, 350, 400, 45, 32'hcafe0002));
        offer(sector(0, 0, 32767, 32767, 511, 1023, 511, 32'hcafe0003));
        offer(sector(-1, -1, 1234, 4321, 359, 719, 359, 32'hcafe0004));
        offer(sector(0, 0, 1000, 1000, 0, 0, 0, 32'hcafe0005));
        offer(sector(0, 0, 32767, 0, 0, 180, 30, 32'hcafe0006));
        offer(sector(0, 0, 800, 800, 0, 6, 0, 32'h00000000));
        offer(sector(0, 0, 900, 900, 0, 354, 0, 32'hcafe0007));
        offer(sector(0, 0, 900, 900, 0, 360, 0, 32'hcafe0008));
        offer(sector(0, 0, 900, 900, 0, 355, 270, 32'hcafe0009));
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // free-running, reset registers, then a long hold-off to fill the block
        directed_sectors();
        hold_len <= HOLD_CYCLES;
        hold_req <= hold_req + 1;
        run_random(80);
        drain();

        program_regs(17'd0, 17'hffff, 17'h1ffff, 17'hffff);
        send_idle_pct = 82;
        run_random(82);
        drain();

        program_regs(17'($urandom_range(65536)), 17'($urandom_range(65535)),
                     17'($urandom_range(65536)), 17'($urandom_range(65535)));
        send_idle_pct = 0;
        stall_pct <= 82;
        run_random(82);
        drain();

        program_regs(17'h1ffff, 17'd0, 17'd0, 17'h8000);
        send_idle_pct = 35;
        stall_pct <= 35;
        run_random(82);
        drain();

        program_regs(17'h10000, 17'd0, 17'h10000, 17'd0);
        send_idle_pct = 0;
        stall_pct <= 0;
        run_random(82);
        drain();

        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Checked %0d rim vertices from %0d sectors under %0d register settings,",
                 vertices, sectors, settings);
        $display("across free, sparse-sender, stalling-receiver and mixed flow plus one hold-off.");
        if (errors == 0 && pending == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
